// ===== rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the multi-finger swipe detector.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_BITS     = 16;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_THREE_EN   = 3'd0;
    localparam logic [2:0] REG_FOUR_EN    = 3'd1;
    localparam logic [2:0] REG_SETTLE     = 3'd2;
    localparam logic [2:0] REG_THRESH_X   = 3'd3;
    localparam logic [2:0] REG_THRESH_Y   = 3'd4;
    localparam logic [2:0] REG_RATIO_NUM  = 3'd5;
    localparam logic [2:0] REG_RATIO_DEN  = 3'd6;

    localparam logic [15:0] RATIO_NUM_DEF = 16'd3;
    localparam logic [15:0] RATIO_DEN_DEF = 16'd2;

    // gesture codes
    localparam logic [3:0] GC_NONE     = 4'd0;
    localparam logic [3:0] GC_RIGHT    = 4'd1;
    localparam logic [3:0] GC_LEFT     = 4'd2;
    localparam logic [3:0] GC_DOWN     = 4'd3;
    localparam logic [3:0] GC_UP       = 4'd4;
    localparam logic [3:0] GC_FOUR_OFS = 4'd4;

    localparam logic [2:0] FINGERS_THREE = 3'd3;
    localparam logic [2:0] FINGERS_FOUR  = 3'd4;
    localparam logic [2:0] FINGERS_ONE   = 3'd1;

    typedef struct packed {
        logic        three_en;
        logic        four_en;
        logic [15:0] settle;
        logic [15:0] thresh_x;
        logic [15:0] thresh_y;
        logic [15:0] ratio_num;
        logic [15:0] ratio_den;
    } cfg_t;

    typedef struct packed {
        logic [2:0]            finger_count;
        logic [2:0]            peak_count;
        logic                  scroll_busy;
        logic [FIELD_BITS-1:0] pos1_x;
        logic [FIELD_BITS-1:0] pos1_y;
        logic [FIELD_BITS-1:0] pos2_x;
        logic [FIELD_BITS-1:0] pos2_y;
        logic [FIELD_BITS-1:0] pos3_x;
        logic [FIELD_BITS-1:0] pos3_y;
        logic [FIELD_BITS-1:0] pos4_x;
        logic [FIELD_BITS-1:0] pos4_y;
    } frame_t;

    typedef struct packed {
        logic       consumed;
        logic       fire;
        logic [3:0] swipe_code;
    } result_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic sum_en;
        logic mul_en;
        logic corr_en;
        logic diff_en;
        logic lock_en;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/multifinger_swipe_detector.sv =====
// ----------------------------------------------------------------------------
// multifinger_swipe_detector
// Three/four-finger swipe gesture detector, one trackpad frame per beat.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      frame fields in tdata (136 bits)
//  m_axis    out  m_axis_tvalid/tready      result fields in tdata (8 bits)
//  apb       in   psel/penable, pready=1    7 config registers at 4*i
//
// After the accept the frame passes through a fixed sequence of sum,
// reciprocal multiply, divide-by-three correction, displacement, lock
// products and commit, and the result beat is then presented. A new frame
// is not taken until the last one has been committed: s_axis_tready is high
// only while the sequencer is idle; a waiting result does not block the next
// accept, but commit waits for the output register. Reset clears config to defaults and swipe state to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module multifinger_swipe_detector
    import msd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // finger_count[2:0], peak_count[5:3], scroll_busy[6], pos1_x[22:7],
    // pos1_y[38:23], pos2_x[54:39], pos2_y[70:55], pos3_x[86:71],
    // pos3_y[102:87], pos4_x[118:103], pos4_y[134:119], zero pad[135]
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // consumed[0], fire[1], swipe_code[5:2], zero pad[7:6]
    output logic [7:0]        m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    cfg_t    cfg;
    frame_t  frame;
    result_t result;
    dp_cmd_t cmd;

    assign frame.finger_count = s_axis_tdata[2:0];
    assign frame.peak_count   = s_axis_tdata[5:3];
    assign frame.scroll_busy  = s_axis_tdata[6];
    assign frame.pos1_x       = s_axis_tdata[22:7];
    assign frame.pos1_y       = s_axis_tdata[38:23];
    assign frame.pos2_x       = s_axis_tdata[54:39];
    assign frame.pos2_y       = s_axis_tdata[70:55];
    assign frame.pos3_x       = s_axis_tdata[86:71];
    assign frame.pos3_y       = s_axis_tdata[102:87];
    assign frame.pos4_x       = s_axis_tdata[118:103];
    assign frame.pos4_y       = s_axis_tdata[134:119];

    assign m_axis_tdata = {2'b00, result.swipe_code, result.fire, result.consumed};

    msd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    msd_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .frame  (frame),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== rtl/msd_cfg.sv =====
// ----------------------------------------------------------------------------
// msd_cfg
// APB register file holding the swipe detector configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_cfg
    import msd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.three_en  <= 1'b1;
            cfg_reg.four_en   <= 1'b1;
            cfg_reg.settle    <= '0;
            cfg_reg.thresh_x  <= '0;
            cfg_reg.thresh_y  <= '0;
            cfg_reg.ratio_num <= RATIO_NUM_DEF;
            cfg_reg.ratio_den <= RATIO_DEN_DEF;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_THREE_EN:  cfg_reg.three_en  <= pwdata[0];
                REG_FOUR_EN:   cfg_reg.four_en   <= pwdata[0];
                REG_SETTLE:    cfg_reg.settle    <= pwdata[15:0];
                REG_THRESH_X:  cfg_reg.thresh_x  <= pwdata[15:0];
                REG_THRESH_Y:  cfg_reg.thresh_y  <= pwdata[15:0];
                REG_RATIO_NUM: cfg_reg.ratio_num <= pwdata[15:0];
                REG_RATIO_DEN: cfg_reg.ratio_den <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THREE_EN:  prdata = {31'd0, cfg_reg.three_en};
            REG_FOUR_EN:   prdata = {31'd0, cfg_reg.four_en};
            REG_SETTLE:    prdata = {16'd0, cfg_reg.settle};
            REG_THRESH_X:  prdata = {16'd0, cfg_reg.thresh_x};
            REG_THRESH_Y:  prdata = {16'd0, cfg_reg.thresh_y};
            REG_RATIO_NUM: prdata = {16'd0, cfg_reg.ratio_num};
            REG_RATIO_DEN: prdata = {16'd0, cfg_reg.ratio_den};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/msd_ctrl.sv =====
// ----------------------------------------------------------------------------
// msd_ctrl
// Sequencer: steps one frame through the datapath stages and owns the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_ctrl
    import msd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MUL,
        S_CORR,
        S_DIFF,
        S_LOCK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                cmd.corr_en = 1'b1;
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = S_LOCK;
            end
            S_LOCK:
            begin
                cmd.lock_en = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the beat
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_SUM)
        else $error("accepted beat did not start the sum step");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/msd_dp.sv =====
// ----------------------------------------------------------------------------
// msd_dp
// Datapath: centroid, displacement, ratio lock and the swipe state.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_dp
    import msd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire dp_cmd_t cmd,
    input  wire cfg_t   cfg,
    input  wire frame_t frame,
    output result_t     result
);

    localparam int CW = COORD_BITS;
    localparam int SW = COORD_BITS + 2;
    localparam int PW = CW + 16;
    // floor(2^SW / 3): quotient estimate is exact or one low
    localparam logic [SW-1:0] RECIP3 = SW'((2 ** SW) / 3);

    // input frame
    logic [2:0]    fc_reg;
    logic [2:0]    peak_reg;
    logic          scroll_reg;
    logic [CW-1:0] px_reg [4];
    logic [CW-1:0] py_reg [4];
    logic          fc4;

    // centroid
    logic [SW-1:0]   sx_reg, sy_reg;
    logic [2*SW-1:0] prodx_reg, prody_reg;
    logic [SW-1:0]   q0x, q0y, rx, ry, qx, qy;
    logic [CW-1:0]   cx_reg, cy_reg;

    // displacement
    logic [CW:0]   dx, dy;
    logic [CW-1:0] adx, ady;
    logic          horiz;
    logic [CW-1:0] major_reg, minor_reg;
    logic          horiz_reg;
    logic [3:0]    dir_reg;

    // lock and threshold
    logic [15:0]   num_eff, den_eff, thr_sel;
    logic [PW-1:0] lhs_reg, rhs_reg;
    logic          axis_ok_reg;

    // swipe state
    logic [CW-1:0] start_x_reg, start_y_reg;
    logic          baseline_valid_reg;
    logic [2:0]    baseline_fingers_reg;
    logic [15:0]   frame_counter_reg;
    logic          triggered_reg;
    logic          latched_reg;

    logic        few;
    logic        enabled;
    logic        blocked;
    logic        new_base;
    logic [15:0] cnt_inc;
    logic        fire_c;
    logic [3:0]  code_c;

    result_t out_reg;

    assign fc4 = (fc_reg == FINGERS_FOUR);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fc_reg     <= frame.finger_count;
            peak_reg   <= frame.peak_count;
            scroll_reg <= frame.scroll_busy;
            px_reg[0]  <= frame.pos1_x[CW-1:0];
            py_reg[0]  <= frame.pos1_y[CW-1:0];
            px_reg[1]  <= frame.pos2_x[CW-1:0];
            py_reg[1]  <= frame.pos2_y[CW-1:0];
            px_reg[2]  <= frame.pos3_x[CW-1:0];
            py_reg[2]  <= frame.pos3_y[CW-1:0];
            px_reg[3]  <= frame.pos4_x[CW-1:0];
            py_reg[3]  <= frame.pos4_y[CW-1:0];
        end
        if (cmd.sum_en)
        begin
            sx_reg <= SW'(px_reg[0]) + SW'(px_reg[1]) + SW'(px_reg[2])
                    + (fc4 ? SW'(px_reg[3]) : '0);
            sy_reg <= SW'(py_reg[0]) + SW'(py_reg[1]) + SW'(py_reg[2])
                    + (fc4 ? SW'(py_reg[3]) : '0);
        end
        if (cmd.mul_en)
        begin
            prodx_reg <= (2*SW)'(sx_reg) * (2*SW)'(RECIP3);
            prody_reg <= (2*SW)'(sy_reg) * (2*SW)'(RECIP3);
        end
        if (cmd.corr_en)
        begin
            cx_reg <= fc4 ? sx_reg[SW-1:2] : qx[CW-1:0];
            cy_reg <= fc4 ? sy_reg[SW-1:2] : qy[CW-1:0];
        end
        if (cmd.diff_en)
        begin
            horiz_reg <= horiz;
            major_reg <= horiz ? adx : ady;
            minor_reg <= horiz ? ady : adx;
            if (horiz)
                dir_reg <= (!dx[CW] && (dx != '0)) ? GC_RIGHT : GC_LEFT;
            else
                dir_reg <= (!dy[CW] && (dy != '0)) ? GC_DOWN : GC_UP;
        end
        if (cmd.lock_en)
        begin
            axis_ok_reg <= (16'(major_reg) >= thr_sel);
            lhs_reg     <= PW'(major_reg) * PW'(den_eff);
            rhs_reg     <= PW'(minor_reg) * PW'(num_eff);
        end
    end

    // divide by three: correct the reciprocal estimate by one step
    always_comb
    begin
        q0x = prodx_reg[2*SW-1:SW];
        q0y = prody_reg[2*SW-1:SW];
        rx  = sx_reg - (q0x + (q0x << 1));
        ry  = sy_reg - (q0y + (q0y << 1));
        qx  = (rx >= SW'(3)) ? q0x + SW'(1) : q0x;
        qy  = (ry >= SW'(3)) ? q0y + SW'(1) : q0y;
    end

    always_comb
    begin
        dx    = {1'b0, cx_reg} - {1'b0, start_x_reg};
        dy    = {1'b0, cy_reg} - {1'b0, start_y_reg};
        adx   = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        ady   = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        horiz = (adx >= ady);
    end

    assign num_eff = (cfg.ratio_num == '0) ? RATIO_NUM_DEF : cfg.ratio_num;
    assign den_eff = (cfg.ratio_den == '0) ? RATIO_DEN_DEF : cfg.ratio_den;
    assign thr_sel = horiz_reg ? cfg.thresh_x : cfg.thresh_y;

    always_comb
    begin
        few      = (fc_reg <= FINGERS_ONE);
        enabled  = ((fc_reg == FINGERS_THREE) && cfg.three_en)
                || ((fc_reg == FINGERS_FOUR) && cfg.four_en);
        blocked  = latched_reg || scroll_reg
                || ((fc_reg == FINGERS_THREE) && (peak_reg >= FINGERS_FOUR));
        new_base = !baseline_valid_reg || (baseline_fingers_reg != fc_reg);
        cnt_inc  = (frame_counter_reg != 16'hFFFF) ? frame_counter_reg + 16'd1
                                                    : frame_counter_reg;
        fire_c   = enabled && !blocked && !new_base && !triggered_reg
                && (cnt_inc > cfg.settle) && axis_ok_reg && (lhs_reg >= rhs_reg);
        code_c   = fc4 ? dir_reg + GC_FOUR_OFS : dir_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg          <= '0;
            start_y_reg          <= '0;
            baseline_valid_reg   <= 1'b0;
            baseline_fingers_reg <= '0;
            frame_counter_reg    <= '0;
            triggered_reg        <= 1'b0;
            latched_reg          <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (few)
                latched_reg <= 1'b0;
            else if (fire_c)
                latched_reg <= 1'b1;

            if (!enabled || blocked)
            begin
                start_x_reg          <= '0;
                start_y_reg          <= '0;
                baseline_valid_reg   <= 1'b0;
                baseline_fingers_reg <= '0;
                frame_counter_reg    <= '0;
                triggered_reg        <= 1'b0;
            end
            else if (new_base)
            begin
                start_x_reg          <= cx_reg;
                start_y_reg          <= cy_reg;
                baseline_valid_reg   <= 1'b1;
                baseline_fingers_reg <= fc_reg;
                frame_counter_reg    <= '0;
                triggered_reg        <= 1'b0;
            end
            else if (!triggered_reg)
            begin
                frame_counter_reg <= cnt_inc;
                if (fire_c)
                    triggered_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.consumed   <= enabled;
            out_reg.fire       <= fire_c;
            out_reg.swipe_code <= fire_c ? code_c : GC_NONE;
        end
    end

    assign result = out_reg;

    a_fire_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && fire_c) |=> (latched_reg && triggered_reg && out_reg.fire))
        else $error("fired gesture did not latch");

    a_lift_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && few) |=> (!latched_reg && !baseline_valid_reg))
        else $error("lift did not clear swipe state");

endmodule

`default_nettype wire

// ===== bench/tb_multifinger_swipe_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multifinger_swipe_detector
// Drives trackpad frames into the swipe detector and checks every result beat
// against an in-bench predictor of the swipe state. The configuration registers
// are written over APB between phases and read back. Both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------

module tb_multifinger_swipe_detector;
    import msd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int FRAME_TARGET = 1650;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // finger_count, peak_count, scroll_busy, pos1_x .. pos4_y, zero pad
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // consumed, fire, swipe_code, zero pad
    logic [7:0]   m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // predictor copy of configuration and swipe state
    cfg_t         cfg_shadow;
    logic [15:0]  base_cx;
    logic [15:0]  base_cy;
    logic         base_valid;
    logic [2:0]   base_fingers;
    logic [15:0]  settle_count;
    logic         fired;
    logic         held;

    result_t      expected_gestures[$];
    int           error_count = 0;
    int           frames_sent = 0;
    int           quiet_cycles = 0;
    int           stall_left = 0;
    bit           steady = 1'b0;

    multifinger_swipe_detector i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void clear_track();
        base_cx      = '0;
        base_cy      = '0;
        base_valid   = 1'b0;
        base_fingers = '0;
        settle_count = '0;
        fired        = 1'b0;
    endfunction

    function automatic result_t predict_swipe(input frame_t f);
        result_t         r;
        logic            enabled;
        logic [17:0]     sum_x;
        logic [17:0]     sum_y;
        logic [15:0]     cen_x;
        logic [15:0]     cen_y;
        int              dx;
        int              dy;
        int              adx;
        int              ady;
        int              major_d;
        int              minor_d;
        int              thr;
        logic            horiz;
        longint          lnum;
        longint          lden;
        logic [3:0]      code;
        r = '0;
        if (f.finger_count <= FINGERS_ONE)
        begin
            held = 1'b0;
            clear_track();
        end
        enabled = (f.finger_count == FINGERS_THREE && cfg_shadow.three_en)
               || (f.finger_count == FINGERS_FOUR && cfg_shadow.four_en);
        if (!enabled)
        begin
            clear_track();
            return r;
        end
        r.consumed = 1'b1;
        if (held || f.scroll_busy
            || (f.finger_count == FINGERS_THREE && f.peak_count >= FINGERS_FOUR))
        begin
            clear_track();
            return r;
        end

        sum_x = 18'(f.pos1_x) + 18'(f.pos2_x) + 18'(f.pos3_x);
        sum_y = 18'(f.pos1_y) + 18'(f.pos2_y) + 18'(f.pos3_y);
        if (f.finger_count == FINGERS_FOUR)
        begin
            sum_x = sum_x + 18'(f.pos4_x);
            sum_y = sum_y + 18'(f.pos4_y);
        end
        cen_x = 16'(sum_x / 18'(f.finger_count));
        cen_y = 16'(sum_y / 18'(f.finger_count));

        if (!base_valid || base_fingers != f.finger_count)
        begin
            base_cx      = cen_x;
            base_cy      = cen_y;
            base_valid   = 1'b1;
            base_fingers = f.finger_count;
            settle_count = '0;
            fired        = 1'b0;
            return r;
        end
        if (fired)
            return r;

        dx = int'(cen_x) - int'(base_cx);
        dy = int'(cen_y) - int'(base_cy);
        if (settle_count != 16'hFFFF)
            settle_count = settle_count + 16'd1;
        if (settle_count <= cfg_shadow.settle)
            return r;

        adx     = (dx < 0) ? -dx : dx;
        ady     = (dy < 0) ? -dy : dy;
        horiz   = (adx >= ady);
        major_d = horiz ? adx : ady;
        minor_d = horiz ? ady : adx;
        thr     = horiz ? int'(cfg_shadow.thresh_x) : int'(cfg_shadow.thresh_y);
        if (major_d < thr)
            return r;

        lnum = (cfg_shadow.ratio_num != 0) ? longint'(cfg_shadow.ratio_num)
                                           : longint'(RATIO_NUM_DEF);
        lden = (cfg_shadow.ratio_den != 0) ? longint'(cfg_shadow.ratio_den)
                                           : longint'(RATIO_DEN_DEF);
        if (longint'(major_d) * lden < longint'(minor_d) * lnum)
            return r;

        if (horiz)
            code = (dx > 0) ? GC_RIGHT : GC_LEFT;
        else
            code = (dy > 0) ? GC_DOWN : GC_UP;
        if (f.finger_count == FINGERS_FOUR)
            code = code + GC_FOUR_OFS;

        fired  = 1'b1;
        held   = 1'b1;
        r.fire = 1'b1;
        r.swipe_code = code;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------------
    function automatic logic [31:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_THREE_EN:  return {31'd0, cfg_shadow.three_en};
            REG_FOUR_EN:   return {31'd0, cfg_shadow.four_en};
            REG_SETTLE:    return {16'd0, cfg_shadow.settle};
            REG_THRESH_X:  return {16'd0, cfg_shadow.thresh_x};
            REG_THRESH_Y:  return {16'd0, cfg_shadow.thresh_y};
            REG_RATIO_NUM: return {16'd0, cfg_shadow.ratio_num};
            REG_RATIO_DEN: return {16'd0, cfg_shadow.ratio_den};
            default:       return 32'd0;
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_THREE_EN:  cfg_shadow.three_en  = value[0];
            REG_FOUR_EN:   cfg_shadow.four_en   = value[0];
            REG_SETTLE:    cfg_shadow.settle    = value[15:0];
            REG_THRESH_X:  cfg_shadow.thresh_x  = value[15:0];
            REG_THRESH_Y:  cfg_shadow.thresh_y  = value[15:0];
            REG_RATIO_NUM: cfg_shadow.ratio_num = value[15:0];
            REG_RATIO_DEN: cfg_shadow.ratio_den = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic read_reg_check(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== reg_value(idx))
        begin
            $display("%0t: register %0d read, expected %h actual %h",
                     $time, idx, reg_value(idx), prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stream drivers
    // ------------------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_frame(input frame_t f);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {1'b0, f.pos4_y, f.pos4_x, f.pos3_y, f.pos3_x, f.pos2_y,
                          f.pos2_x, f.pos1_y, f.pos1_x, f.scroll_busy, f.peak_count,
                          f.finger_count};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_gestures.push_back(predict_swipe(f));
        frames_sent++;
    endtask

    // finger i sits at (x + i*spread, y + i*spread) plus a little jitter
    function automatic frame_t finger_frame(input int fc, input int peak, input bit scroll,
                                            input int x, input int y,
                                            input int spread, input int jit);
        frame_t f;
        f.finger_count = 3'(fc);
        f.peak_count   = 3'(peak);
        f.scroll_busy  = scroll;
        f.pos1_x = 16'(x + $urandom_range(0, jit));
        f.pos1_y = 16'(y + $urandom_range(0, jit));
        f.pos2_x = 16'(x + spread + $urandom_range(0, jit));
        f.pos2_y = 16'(y + spread + $urandom_range(0, jit));
        f.pos3_x = 16'(x + 2 * spread + $urandom_range(0, jit));
        f.pos3_y = 16'(y + 2 * spread + $urandom_range(0, jit));
        f.pos4_x = 16'(x + 3 * spread + $urandom_range(0, jit));
        f.pos4_y = 16'(y + 3 * spread + $urandom_range(0, jit));
        return f;
    endfunction

    function automatic frame_t noise_frame();
        frame_t f;
        f.finger_count = 3'($urandom_range(0, 7));
        f.peak_count   = 3'($urandom_range(0, 7));
        f.scroll_busy  = 1'($urandom_range(0, 1));
        f.pos1_x = 16'($urandom);
        f.pos1_y = 16'($urandom);
        f.pos2_x = 16'($urandom);
        f.pos2_y = 16'($urandom);
        f.pos3_x = 16'($urandom);
        f.pos3_y = 16'($urandom);
        f.pos4_x = 16'($urandom);
        f.pos4_y = 16'($urandom);
        return f;
    endfunction

    task automatic send_at(input int fc, input int peak, input bit scroll,
                           input int x, input int y);
        send_frame(finger_frame(fc, peak, scroll, x, y, 0, 0));
    endtask

    // one contact sequence: fingers drift in a straight line, then usually lift
    task automatic swipe_run(input int fingers);
        int n;
        int k;
        int mag;
        int step_x;
        int step_y;
        int spread;
        int jit;
        int margin;
        int x;
        int y;
        int peak;
        n = $urandom_range(2, 10);
        k = $urandom_range(0, 9);
        mag = (k < 4) ? 40 : (k < 8) ? 400 : 2500;
        step_x = int'($urandom_range(0, 2 * mag)) - mag;
        step_y = int'($urandom_range(0, 2 * mag)) - mag;
        if ($urandom_range(0, 1) == 0)
            step_y = step_y / 8;
        else if ($urandom_range(0, 1) == 0)
            step_x = step_x / 8;
        spread = $urandom_range(0, 600);
        jit    = $urandom_range(0, 7);
        margin = n * mag;
        x = $urandom_range(margin, 65535 - margin - 3 * spread - jit);
        y = $urandom_range(margin, 65535 - margin - 3 * spread - jit);
        if (fingers == 3)
            peak = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : 3;
        else if (fingers == 4)
            peak = $urandom_range(4, 7);
        else
            peak = fingers;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_frame(noise_frame());
            else
                send_frame(finger_frame(fingers, peak, $urandom_range(0, 19) == 0,
                                        x + k * step_x, y + k * step_y, spread, jit));
        end
        if ($urandom_range(0, 9) < 6)
            send_at($urandom_range(0, 1), $urandom_range(0, 1), 1'b0,
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_gestures.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic reconfigure(input int three, input int four, input int settle,
                               input int thr_x, input int thr_y,
                               input int lock_n, input int lock_d);
        wait_idle();
        write_reg(REG_THREE_EN, three);
        write_reg(REG_FOUR_EN, four);
        write_reg(REG_SETTLE, settle);
        write_reg(REG_THRESH_X, thr_x);
        write_reg(REG_THRESH_Y, thr_y);
        write_reg(REG_RATIO_NUM, lock_n);
        write_reg(REG_RATIO_DEN, lock_d);
    endtask

    function automatic int rand_field(input int small_hi);
        int r;
        r = $urandom_range(0, 19);
        if (r < 6)
            return 0;
        if (r < 18)
            return $urandom_range(1, small_hi);
        if (r < 19)
            return 65535;
        return $urandom_range(0, 65535);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_register_access();
        int idx;
        for (idx = 0; idx < 7; idx++)
            read_reg_check(3'(idx));
        for (idx = 0; idx < 7; idx++)
            write_reg(3'(idx), 32'hFFFF_FFFF);
        for (idx = 0; idx < 7; idx++)
            read_reg_check(3'(idx));
        for (idx = 0; idx < 7; idx++)
            write_reg(3'(idx), 32'h0000_0000);
        for (idx = 0; idx < 7; idx++)
            read_reg_check(3'(idx));
        reconfigure(1, 1, 0, 0, 0, RATIO_NUM_DEF, RATIO_DEN_DEF);
        for (idx = 0; idx < 7; idx++)
            read_reg_check(3'(idx));
    endtask

    task automatic test_directed_cases();
        send_at(0, 0, 0, 0, 0);
        send_at(3, 3, 0, 0, 0);
        send_at(3, 3, 0, 0, 0);             // no travel at all: left
        send_at(3, 3, 0, 900, 0);           // still latched
        send_at(1, 1, 0, 0, 0);
        send_at(4, 4, 0, 65535, 65535);
        send_at(4, 7, 0, 0, 0);             // equal magnitudes go horizontal
        send_at(0, 0, 0, 0, 0);
        send_at(3, 3, 0, 1000, 1000);
        send_at(3, 3, 0, 1000, 5000);
        send_at(1, 3, 0, 0, 0);
        send_at(3, 3, 0, 5000, 5000);
        send_at(3, 5, 0, 9000, 5000);       // fourth finger seen: blocked
        send_at(3, 3, 1, 9000, 5000);       // scroll owns the contact
        send_at(3, 3, 0, 5000, 5000);
        send_at(3, 3, 0, 9000, 5600);
        send_at(0, 0, 0, 0, 0);
        send_at(4, 4, 0, 20000, 20000);
        send_at(3, 3, 0, 20000, 10000);     // count change restarts baseline
        send_at(3, 3, 0, 20000, 30000);
        send_at(1, 0, 0, 0, 0);
        send_at(4, 4, 0, 20000, 20000);
        send_at(4, 6, 0, 20000, 10000);
        send_at(2, 2, 1, 300, 300);
        send_at(5, 5, 0, 40000, 100);
        send_at(6, 6, 0, 100, 40000);
        send_at(7, 7, 1, 65535, 65535);
    endtask

    task automatic test_enable_masks();
        int k;
        reconfigure(0, 1, 0, 0, 0, 3, 2);
        for (k = 0; k < 6; k++)
            swipe_run((k % 2 == 0) ? 3 : 4);
        reconfigure(1, 0, 0, 0, 0, 3, 2);
        for (k = 0; k < 6; k++)
            swipe_run((k % 2 == 0) ? 3 : 4);
        reconfigure(0, 0, 1, 20, 20, 3, 2);
        for (k = 0; k < 4; k++)
            swipe_run((k % 2 == 0) ? 3 : 4);
    endtask

    task automatic test_settle_and_thresholds();
        int k;
        reconfigure(1, 1, 0, 65535, 65535, 0, 0);
        send_at(3, 3, 0, 0, 0);
        send_at(3, 3, 0, 65535, 0);         // travel equals the largest threshold
        send_at(0, 0, 0, 0, 0);
        send_at(4, 4, 0, 0, 65535);
        send_at(4, 4, 0, 0, 0);
        send_at(1, 1, 0, 0, 0);
        send_at(3, 3, 0, 0, 0);
        send_at(3, 3, 0, 65534, 0);         // one short
        send_at(0, 0, 0, 0, 0);
        // counter can never pass the settle count
        reconfigure(1, 1, 65535, 0, 0, 3, 2);
        for (k = 0; k < 5; k++)
            swipe_run($urandom_range(3, 4));
        reconfigure(1, 1, 3, 200, 300, 0, 0);
        for (k = 0; k < 8; k++)
            swipe_run($urandom_range(3, 4));
    endtask

    task automatic test_lock_ratio();
        int k;
        reconfigure(1, 1, 0, 0, 0, 3, 2);
        send_at(3, 3, 0, 5000, 5000);
        send_at(3, 3, 0, 6000, 5900);       // too diagonal
        send_at(3, 3, 0, 6000, 6000);
        send_at(3, 3, 0, 6000, 5600);
        send_at(0, 0, 0, 0, 0);
        reconfigure(1, 1, 0, 0, 0, 65535, 1);
        for (k = 0; k < 6; k++)
            swipe_run($urandom_range(3, 4));
        reconfigure(1, 1, 1, 50, 50, 1, 65535);
        for (k = 0; k < 6; k++)
            swipe_run($urandom_range(3, 4));
        reconfigure(1, 1, 0, 100, 100, 0, 5);
        for (k = 0; k < 6; k++)
            swipe_run($urandom_range(3, 4));
        reconfigure(1, 1, 2, 100, 100, 7, 0);
        for (k = 0; k < 6; k++)
            swipe_run($urandom_range(3, 4));
    endtask

    task automatic test_random_frames();
        int phase;
        int target;
        int k;
        phase = 0;
        while (frames_sent < FRAME_TARGET)
        begin
            reconfigure($urandom_range(0, 9) < 8, $urandom_range(0, 9) < 8,
                        rand_field(4), rand_field(3000), rand_field(3000),
                        rand_field(8), rand_field(8));
            steady = (phase % 4 == 3);
            target = frames_sent + 120;
            while (frames_sent < target)
            begin
                if ($urandom_range(0, 19) < 3)
                begin
                    for (k = 0; k < 3; k++)
                        send_frame(noise_frame());
                end
                else if ($urandom_range(0, 9) < 9)
                    swipe_run($urandom_range(3, 4));
                else
                    swipe_run($urandom_range(0, 7));
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result sink, checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25)
            stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
                                                      : $urandom_range(8, 40);
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.consumed   = m_axis_tdata[0];
            got.fire       = m_axis_tdata[1];
            got.swipe_code = m_axis_tdata[5:2];
            if (expected_gestures.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_gestures.pop_front();
                if (got.consumed !== want.consumed)
                begin
                    $display("%0t: consumed expected %0d actual %0d",
                             $time, want.consumed, got.consumed);
                    error_count++;
                end
                if (got.fire !== want.fire)
                begin
                    $display("%0t: fire expected %0d actual %0d",
                             $time, want.fire, got.fire);
                    error_count++;
                end
                if (got.swipe_code !== want.swipe_code)
                begin
                    $display("%0t: swipe_code expected %0d actual %0d",
                             $time, want.swipe_code, got.swipe_code);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cfg_shadow = '{three_en: 1'b1, four_en: 1'b1, settle: 16'd0, thresh_x: 16'd0,
                       thresh_y: 16'd0, ratio_num: RATIO_NUM_DEF,
                       ratio_den: RATIO_DEN_DEF};
        clear_track();
        held = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_cases();
        test_enable_masks();
        test_settle_and_thresholds();
        test_lock_ratio();
        test_random_frames();
        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_gestures.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
